// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define QPR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds while reset is high.
`define QPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/qpr_pkg.sv -----
// Shared types, constants and term tables for the quaternion product unit.
// Depends on nothing.
package qpr_pkg;

  // Default fraction width of the fixed point format
  localparam int FRAC_BITS_DEF = 16;

  // Width of a full sum of four signed 64-bit partial products
  localparam int SUM_W = 66;

  // One quaternion: [0] = w, [1] = x, [2] = y, [3] = z
  typedef logic [3:0][31:0] quat_t;

  // Component of B multiplied by component t of A for result component c
  localparam logic [1:0] TERM_B [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // Terms that enter the Hamilton sum negated
  localparam logic TERM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

endpackage

// ----- rtl/core/quaternion_product_and_rotate_unit.sv -----
// Accept to out_valid passes through seven registers, so up to seven requests
// are in flight. Throughput: one request per cycle while results drain, and
// bubbles ahead of a stalled result still fill while in_ready stays high.
// Reset clears only valid bits; data registers carry no reset.
// Depends on qpr_pkg and qpr_product.
module quaternion_product_and_rotate_unit import qpr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] a_w,
  input  logic [31:0] a_x,
  input  logic [31:0] a_y,
  input  logic [31:0] a_z,
  input  logic [31:0] b_w,
  input  logic [31:0] b_x,
  input  logic [31:0] b_y,
  input  logic [31:0] b_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] r_w,
  output logic [31:0] r_x,
  output logic [31:0] r_y,
  output logic [31:0] r_z,
  output logic        saturated
);

  localparam int SIDE1_W = 1 + 128;
  localparam int SIDE2_W = 1 + 128 + 1;

  quat_t              a_in;
  quat_t              b_in;
  logic [SIDE1_W-1:0] side1_out;
  logic               p1_valid;
  logic               p1_ready;
  quat_t              t_q;
  logic [3:0]         t_sat;
  logic               p2_valid;
  logic               p2_ready;
  quat_t              r2_q;
  logic [3:0]         r2_sat;
  logic [SIDE2_W-1:0] side2_out;
  logic               act2;
  quat_t              t2;
  logic               sat1_any;
  quat_t              r_next;
  logic               sat_next;
  quat_t              r;

  // Zero the scalar of B when rotating a point
  assign a_in = {a_z, a_y, a_x, a_w};
  assign b_in = {b_z, b_y, b_x, action ? 32'd0 : b_w};

  // First product: A*B or A*(0,p)
  qpr_product #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE1_W)) u_prod1 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .a        (a_in),
    .b        (b_in),
    .conj_b   (1'b0),
    .side_in  ({action, a_in}),
    .out_valid(p1_valid),
    .out_ready(p1_ready),
    .q        (t_q),
    .sat      (t_sat),
    .side_out (side1_out)
  );

  // Second product: t*conj(A); compose requests carry t alongside
  qpr_product #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE2_W)) u_prod2 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p1_valid),
    .in_ready (p1_ready),
    .a        (t_q),
    .b        (side1_out[127:0]),
    .conj_b   (1'b1),
    .side_in  ({side1_out[SIDE1_W-1], t_q, |t_sat}),
    .out_valid(p2_valid),
    .out_ready(p2_ready),
    .q        (r2_q),
    .sat      (r2_sat),
    .side_out (side2_out)
  );

  assign act2     = side2_out[SIDE2_W-1];
  assign t2       = side2_out[128:1];
  assign sat1_any = side2_out[0];

  // Pick the result; rotation drops the scalar and its clip flag
  always_comb begin
    if (act2) begin
      r_next   = {r2_q[3], r2_q[2], r2_q[1], 32'd0};
      sat_next = sat1_any | (|r2_sat[3:1]);
    end else begin
      r_next   = t2;
      sat_next = sat1_any;
    end
  end

  // Output register
  assign p2_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p2_ready) begin
      out_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_ready) begin
      r         <= r_next;
      saturated <= sat_next;
    end
  end

  assign r_w = r[0];
  assign r_x = r[1];
  assign r_y = r[2];
  assign r_z = r[3];

endmodule

// ----- rtl/core/qpr_product.sv -----
// Three-stage pipelined quaternion product a*b or a*conj(b): multiply,
// full-width sum with rounding, shift and saturate. Depends on qpr_pkg.
module qpr_product import qpr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  quat_t             a,
  input  quat_t             b,
  input  logic              conj_b,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  input  logic              out_ready,
  output quat_t             q,
  output logic [3:0]        sat,
  output logic [SIDE_W-1:0] side_out
);

  localparam logic signed [SUM_W-1:0] RND =
    {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // Stage 1: partial products
  logic                     v1;
  logic                     ready1;
  logic signed [63:0]       prod [4][4];
  logic                     neg  [4][4];
  logic [SIDE_W-1:0]        side1;

  // Stage 2: rounded full sums
  logic                     v2;
  logic                     ready2;
  logic signed [SUM_W-1:0]  sum      [4];
  logic signed [SUM_W-1:0]  sum_next [4];
  logic [SIDE_W-1:0]        side2;

  // Stage 3: saturated components
  logic                     ready3;
  quat_t                    q_next;
  logic [3:0]               sat_next;

  // Advance each stage when it is empty or its successor moves
  assign ready3   = !out_valid || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) out_valid <= v2;
    end
  end

  // Multiply every term of the product
  always_ff @(posedge clk) begin
    if (ready1) begin
      for (int c = 0; c < 4; c++) begin
        for (int t = 0; t < 4; t++) begin
          prod[c][t] <= 64'($signed(a[t])) * 64'($signed(b[TERM_B[c][t]]));
          neg[c][t]  <= TERM_NEG[c][t] ^ (conj_b && (TERM_B[c][t] != 2'd0));
        end
      end
      side1 <= side_in;
    end
  end

  // Sum the four terms of each component at full width and add the round bit
  always_comb begin
    logic signed [SUM_W-1:0] ext;
    for (int c = 0; c < 4; c++) begin
      sum_next[c] = RND;
      for (int t = 0; t < 4; t++) begin
        ext = {{(SUM_W-64){prod[c][t][63]}}, prod[c][t]};
        sum_next[c] = neg[c][t] ? (sum_next[c] - ext) : (sum_next[c] + ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      for (int c = 0; c < 4; c++) sum[c] <= sum_next[c];
      side2 <= side1;
    end
  end

  // Drop the fraction bits and clip to the 32-bit range
  always_comb begin
    logic signed [SUM_W-1:0] sh;
    logic [SUM_W-32:0]       hi;
    for (int c = 0; c < 4; c++) begin
      sh = sum[c] >>> FRAC_BITS;
      hi = sh[SUM_W-1:31];
      if ((&hi) || !(|hi)) begin
        q_next[c]   = sh[31:0];
        sat_next[c] = 1'b0;
      end else begin
        q_next[c]   = sh[SUM_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        sat_next[c] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      q        <= q_next;
      sat      <= sat_next;
      side_out <= side2;
    end
  end

endmodule

// ----- rtl/core/qpr_checker.sv -----
// Port-level assertions for the quaternion product unit, and their bind.
// Depends on assert_macros.svh and quaternion_product_and_rotate_unit.
`include "assert_macros.svh"

module qpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] r_w,
  input logic [31:0] r_x,
  input logic [31:0] r_y,
  input logic [31:0] r_z,
  input logic        saturated
);

  localparam logic [3:0] MAX_IN_FLIGHT = 4'd7;

  logic       in_fire;
  logic       out_fire;
  logic [3:0] in_flight;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Track requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 4'd0;
    end else begin
      in_flight <= in_flight + {3'd0, in_fire} - {3'd0, out_fire};
    end
  end

  `QPR_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable({r_w, r_x, r_y, r_z, saturated}), "result dropped or changed")
  `QPR_ASSERT(a_no_invent, clk, rst, out_valid |-> in_flight != 4'd0, "result without request")
  `QPR_ASSERT(a_capacity, clk, rst, in_flight <= MAX_IN_FLIGHT, "too many requests in flight")
  `QPR_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid, "valid after reset")

endmodule

bind quaternion_product_and_rotate_unit qpr_checker u_qpr_checker (.*);

// ----- tb/tb_quaternion_product_and_rotate_unit.sv -----
// Self-checking testbench for quaternion_product_and_rotate_unit: directed and random
// Hamilton products and point rotations, checked against an in-bench fixed-point predictor.
// Depends on qpr_pkg and the quaternion_product_and_rotate_unit RTL.
module tb_quaternion_product_and_rotate_unit;
  import qpr_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int STALL_MAX = 15;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MISMATCH_SHOWN = 10;

  // Action codes
  localparam logic ACT_COMPOSE = 1'b0;
  localparam logic ACT_ROTATE = 1'b1;

  // Frequent Q16.16 words
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;
  localparam logic [31:0] NEG_HALF = 32'hFFFF_8000;
  localparam logic [31:0] MAX_V = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_V = 32'h8000_0000;
  localparam logic [31:0] ROOT_HALF = 32'd46341;

  localparam logic signed [65:0] HALF_LSB = 66'sd1 <<< (FRAC - 1);
  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  typedef enum {VAL_FULL, VAL_SMALL, VAL_EDGE, VAL_MIX} value_kind_t;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        sat;
  } result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [31:0] a_w, a_x, a_y, a_z;
  logic [31:0] b_w, b_x, b_y, b_z;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] r_w, r_x, r_y, r_z;
  logic        saturated;

  result_t pending_results[$];
  int      fail_count;
  int      idle_cycles;
  bit      send_gaps_on;
  bit      recv_stalls_on;

  quaternion_product_and_rotate_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .a_w      (a_w),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_w      (b_w),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .r_w      (r_w),
    .r_x      (r_x),
    .r_y      (r_y),
    .r_z      (r_z),
    .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exact signed partial product, optionally negated
  function automatic logic signed [65:0] signed_term(input logic [31:0] u,
                                                      input logic [31:0] v, input bit neg);
    logic signed [65:0] p;
    p = $signed({{34{u[31]}}, u}) * $signed({{34{v[31]}}, v});
    return neg ? -p : p;
  endfunction

  // Round to nearest (ties up), drop the fraction and clip to 32 bits
  function automatic logic [31:0] round_clip(input logic signed [65:0] acc, output bit clip);
    logic signed [65:0] r;
    r = (acc + HALF_LSB) >>> FRAC;
    clip = 1'b0;
    if (r > MAX32) begin
      r = MAX32;
      clip = 1'b1;
    end else if (r < MIN32) begin
      r = MIN32;
      clip = 1'b1;
    end
    return r[31:0];
  endfunction

  // Hamilton product a*b, or a*conj(b); conjugation flips every term that uses b's vector part
  function automatic quat_t ham_product(input quat_t a, input quat_t b, input bit conj_b,
                                        output logic [3:0] clip);
    logic signed [65:0] acc [4];
    quat_t prod;
    bit nc;
    bit cl;
    nc = conj_b;
    acc[0] = signed_term(a[0], b[0], 1'b0) + signed_term(a[1], b[1], !nc)
           + signed_term(a[2], b[2], !nc) + signed_term(a[3], b[3], !nc);
    acc[1] = signed_term(a[0], b[1], nc) + signed_term(a[1], b[0], 1'b0)
           + signed_term(a[2], b[3], nc) + signed_term(a[3], b[2], !nc);
    acc[2] = signed_term(a[0], b[2], nc) + signed_term(a[1], b[3], !nc)
           + signed_term(a[2], b[0], 1'b0) + signed_term(a[3], b[1], nc);
    acc[3] = signed_term(a[0], b[3], nc) + signed_term(a[1], b[2], nc)
           + signed_term(a[2], b[1], !nc) + signed_term(a[3], b[0], 1'b0);
    for (int c = 0; c < 4; c++) begin
      prod[c] = round_clip(acc[c], cl);
      clip[c] = cl;
    end
    return prod;
  endfunction

  // Expected result of one request
  function automatic result_t predict_result(input logic act, input quat_t a, input quat_t b);
    quat_t point;
    quat_t mid;
    quat_t fin;
    logic [3:0] clip1;
    logic [3:0] clip2;
    result_t res;
    if (act == ACT_COMPOSE) begin
      fin = ham_product(a, b, 1'b0, clip1);
      res.sat = |clip1;
    end else begin
      // Rotation: the scalar of the second product is dropped along with its clip
      point = b;
      point[0] = '0;
      mid = ham_product(a, point, 1'b0, clip1);
      fin = ham_product(mid, a, 1'b1, clip2);
      fin[0] = '0;
      res.sat = (|clip1) | (|clip2[3:1]);
    end
    res.w = fin[0];
    res.x = fin[1];
    res.y = fin[2];
    res.z = fin[3];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic quat_t quat(input logic [31:0] w, input logic [31:0] x,
                                 input logic [31:0] y, input logic [31:0] z);
    quat_t q;
    q[0] = w;
    q[1] = x;
    q[2] = y;
    q[3] = z;
    return q;
  endfunction

  function automatic logic [31:0] rand_word(input value_kind_t kind);
    value_kind_t pick;
    case (kind)
      VAL_FULL: return $urandom();
      // Roughly -4.0 to +4.0
      VAL_SMALL: return $urandom_range(0, 2 ** 19) - 32'h0004_0000;
      VAL_EDGE: begin
        case ($urandom_range(0, 7))
          0: return '0;
          1: return ONE;
          2: return NEG_ONE;
          3: return MAX_V;
          4: return MIN_V;
          5: return HALF;
          6: return 32'd1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        pick = value_kind_t'($urandom_range(0, 2));
        return rand_word(pick);
      end
    endcase
  endfunction

  function automatic quat_t rand_quat(input value_kind_t kind);
    return quat(rand_word(kind), rand_word(kind), rand_word(kind), rand_word(kind));
  endfunction

  // Send one request; called and returning at a falling edge
  task automatic send_request(input logic act, input quat_t a, input quat_t b);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    {a_z, a_y, a_x, a_w} <= a;
    {b_z, b_y, b_x, b_w} <= b;
    // Hold until accepted, then log the expected result
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(act, a, b));
    @(negedge clk);
  endtask

  task automatic run_random(input int count, input value_kind_t kind);
    for (int i = 0; i < count; i++) begin
      send_request(logic'($urandom_range(0, 1)), rand_quat(kind), rand_quat(kind));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_compose_directed();
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
    send_request(ACT_COMPOSE, quat(ONE, 0, 0, 0), quat(ONE, 0, 0, 0));
    // i*j = k and j*i = -k
    send_request(ACT_COMPOSE, quat(0, ONE, 0, 0), quat(0, 0, ONE, 0));
    send_request(ACT_COMPOSE, quat(0, 0, ONE, 0), quat(0, ONE, 0, 0));
    // Largest magnitudes, kept exact before the clip
    send_request(ACT_COMPOSE, quat(MAX_V, MAX_V, MAX_V, MAX_V), quat(MAX_V, MAX_V, MAX_V, MAX_V));
    send_request(ACT_COMPOSE, quat(MIN_V, MIN_V, MIN_V, MIN_V), quat(MIN_V, MIN_V, MIN_V, MIN_V));
    send_request(ACT_COMPOSE, quat(MIN_V, MAX_V, MIN_V, MAX_V), quat(MAX_V, MIN_V, MAX_V, MIN_V));
    // Rounding ties go toward plus infinity
    send_request(ACT_COMPOSE, quat(32'd1, 0, 0, 0), quat(HALF, 0, 0, 0));
    send_request(ACT_COMPOSE, quat(32'd1, 0, 0, 0), quat(NEG_HALF, 0, 0, 0));
    // Right at the range limits, and one step past
    send_request(ACT_COMPOSE, quat(MAX_V, 0, 0, 0), quat(ONE, 0, 0, 0));
    send_request(ACT_COMPOSE, quat(MIN_V, 0, 0, 0), quat(ONE, 0, 0, 0));
    send_request(ACT_COMPOSE, quat(MIN_V, 0, 0, 0), quat(NEG_ONE, 0, 0, 0));
    send_request(ACT_COMPOSE, quat(0, 0, 0, 0), quat(0, 0, 0, 0));
  endtask

  task automatic test_rotate_directed();
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
    // Identity; B scalar must be ignored
    send_request(ACT_ROTATE, quat(ONE, 0, 0, 0), quat(MAX_V, ONE, 2 * ONE, 3 * ONE));
    // Quarter turn about z and half turn about x
    send_request(ACT_ROTATE, quat(ROOT_HALF, 0, 0, ROOT_HALF), quat(0, ONE, 0, 0));
    send_request(ACT_ROTATE, quat(0, ONE, 0, 0), quat(MIN_V, 0, ONE, 0));
    // Most negative A components through the conjugate
    send_request(ACT_ROTATE, quat(MIN_V, MIN_V, MIN_V, MIN_V), quat(0, 32'd3, NEG_ONE, 32'd1));
    send_request(ACT_ROTATE, quat(MIN_V, MIN_V, MIN_V, MIN_V), quat(0, MAX_V, MAX_V, MIN_V));
    send_request(ACT_ROTATE, quat(MIN_V, 0, 0, 0), quat(0, ONE, 0, 0));
    // Clip in the first product feeds the second
    send_request(ACT_ROTATE, quat(MAX_V, 0, 0, 0), quat(0, MAX_V, MAX_V, MAX_V));
    send_request(ACT_ROTATE, quat(MAX_V, MAX_V, 0, 0), quat(0, MAX_V, 0, 0));
    send_request(ACT_ROTATE, quat(0, 0, 0, 0), quat(MAX_V, MAX_V, MIN_V, ONE));
  endtask

  task automatic test_random_small();
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
    run_random(600, VAL_SMALL);
  endtask

  task automatic test_random_streaming();
    send_gaps_on = 1'b0;
    recv_stalls_on = 1'b0;
    run_random(400, VAL_MIX);
  endtask

  task automatic test_random_full_range();
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
    run_random(450, VAL_FULL);
  endtask

  task automatic test_random_edges();
    send_gaps_on = 1'b0;
    recv_stalls_on = 1'b1;
    run_random(300, VAL_EDGE);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Drive out_ready with a random stall before each result
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = recv_stalls_on ? $urandom_range(0, STALL_MAX) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    if (fail_count <= MISMATCH_SHOWN)
      $display("mismatch %s: expected %h, got %h", field, want, got);
  endtask

  // Compare each delivered result with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result r_w", '0, r_w);
      end else begin
        want = pending_results.pop_front();
        if (r_w !== want.w) note_mismatch("r_w", want.w, r_w);
        if (r_x !== want.x) note_mismatch("r_x", want.x, r_x);
        if (r_y !== want.y) note_mismatch("r_y", want.y, r_y);
        if (r_z !== want.z) note_mismatch("r_z", want.z, r_z);
        if (saturated !== want.sat) note_mismatch("saturated", 32'(want.sat), 32'(saturated));
      end
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_COMPOSE;
    {a_z, a_y, a_x, a_w} = '0;
    {b_z, b_y, b_x, b_w} = '0;
    fail_count = 0;
    idle_cycles = 0;
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_compose_directed();
    test_rotate_directed();
    test_random_small();
    test_random_streaming();
    test_random_full_range();
    test_random_edges();

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    recv_stalls_on = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
